### hdl/gds_pkg.sv
// ---------------------------------------------------------------------------
// gds_pkg: shared types and constants for the date subtract block
// Field widths, action codes, sequencer states and calendar helper functions.
// ---------------------------------------------------------------------------
package gds_pkg;

    localparam int AMOUNT_BITS = 12;
    localparam int YEAR_BITS   = 16;
    localparam int DAY_BITS    = 5;
    localparam int MONTH_BITS  = 4;
    localparam int ACTION_BITS = 2;

    // Remainder of year mod 400 fits in 9 bits
    localparam int LEAP_CYCLE    = 400;
    localparam int CENTURY       = 100;
    localparam int YREM_BITS     = 9;

    // year / 400 by reciprocal multiply: error stays below 2^-9 < 1/400 for
    // every year below 2^YEAR_BITS, so the floor is exact
    localparam int RECIP_SHIFT   = YEAR_BITS + 9;
    localparam int RECIP_BITS    = YEAR_BITS + 1;
    localparam int QUOT_BITS     = YEAR_BITS - 8;
    localparam int PROD_BITS     = YEAR_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_400 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(LEAP_CYCLE - 1)) / 64'(LEAP_CYCLE));

    // Common widths for mixed compares
    localparam int AMT_CMP_BITS  = (AMOUNT_BITS > DAY_BITS) ? AMOUNT_BITS : DAY_BITS;
    localparam int YR_CMP_BITS   = (AMOUNT_BITS > YEAR_BITS) ? AMOUNT_BITS : YEAR_BITS;

    localparam logic [MONTH_BITS-1:0] JANUARY  = MONTH_BITS'(1);
    localparam logic [MONTH_BITS-1:0] FEBRUARY = MONTH_BITS'(2);
    localparam logic [MONTH_BITS-1:0] APRIL    = MONTH_BITS'(4);
    localparam logic [MONTH_BITS-1:0] JUNE     = MONTH_BITS'(6);
    localparam logic [MONTH_BITS-1:0] SEPTEMBER = MONTH_BITS'(9);
    localparam logic [MONTH_BITS-1:0] NOVEMBER = MONTH_BITS'(11);
    localparam logic [MONTH_BITS-1:0] DECEMBER = MONTH_BITS'(12);

    localparam logic [DAY_BITS-1:0] DAY_FIRST  = DAY_BITS'(1);
    localparam logic [DAY_BITS-1:0] DAY_28     = DAY_BITS'(28);
    localparam logic [DAY_BITS-1:0] DAY_29     = DAY_BITS'(29);
    localparam logic [DAY_BITS-1:0] DAY_30     = DAY_BITS'(30);
    localparam logic [DAY_BITS-1:0] DAY_31     = DAY_BITS'(31);

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_DAYS   = 2'd0,
        ACT_MONTHS = 2'd1,
        ACT_YEARS  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QUOT,
        ST_MOD,
        ST_CLAMP,
        ST_DAYS,
        ST_MONTHS,
        ST_YSUB,
        ST_YFIX,
        ST_DONE
    } state_t;

    // Leap test from year mod 400 (mod 4 is the low two bits, since 4 divides 400)
    function automatic logic is_leap(input logic [YREM_BITS-1:0] r);
        logic cent;
        cent = (r == YREM_BITS'(CENTURY)) || (r == YREM_BITS'(2 * CENTURY))
            || (r == YREM_BITS'(3 * CENTURY));
        return (r == '0) || ((r[1:0] == 2'b00) && !cent);
    endfunction

    function automatic logic [DAY_BITS-1:0] days_in(input logic [MONTH_BITS-1:0] m,
                                                    input logic leap);
        logic [DAY_BITS-1:0] len;
        case (m) inside
            APRIL, JUNE, SEPTEMBER, NOVEMBER: len = DAY_30;
            FEBRUARY:                         len = leap ? DAY_29 : DAY_28;
            default:                          len = DAY_31;
        endcase
        return len;
    endfunction

endpackage

### hdl/gregorian_date_subtract.sv
// ---------------------------------------------------------------------------
// gregorian_date_subtract: step a Gregorian date back by days, months or years
// Iterative sequencer around one year-remainder unit and one month stepper.
// ---------------------------------------------------------------------------
// A word on the source side carries a starting date, an action (0 days,
// 1 months, 2 years, 3 pass-through) and an amount; one result word comes
// back with the earlier date and an underflow flag (result saturated at
// 1/1/0). Out-of-range months clamp to 1..12 and days to 1..month length.
// The block works on one word at a time and stalls the source until the
// sequencer is back in idle. After a word is taken the sequencer forms
// year / 400 by reciprocal multiply, then year mod 400, then clamps the
// day, then walks, then loads the result register in its done state.
// Days step back one month at a time and close with a final step (about
// amount/30 months); months step back one month at a time; years take a
// subtract step, a second remainder pass on the new year and a 29 February
// fix step; pass-through has no walk. The next word is taken back in idle,
// after the result is loaded. Leap years are tracked as year mod 400,
// decremented with the year during the walk. The finished word sits in an
// output register, so a new source word may be taken while it waits.
// ---------------------------------------------------------------------------
module gregorian_date_subtract (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               src_valid,
    output logic                               src_stall,
    input  logic [gds_pkg::ACTION_BITS-1:0]    action,
    input  logic [gds_pkg::AMOUNT_BITS-1:0]    amount,
    input  logic [gds_pkg::DAY_BITS-1:0]       day,
    input  logic [gds_pkg::MONTH_BITS-1:0]     month,
    input  logic [gds_pkg::YEAR_BITS-1:0]      year,
    output logic                               dst_valid,
    input  logic                               dst_stall,
    output logic [gds_pkg::DAY_BITS-1:0]       new_day,
    output logic [gds_pkg::MONTH_BITS-1:0]     new_month,
    output logic [gds_pkg::YEAR_BITS-1:0]      new_year,
    output logic                               underflow
);
    import gds_pkg::*;

    // control
    state_t                   state_reg, state_next;
    logic                     dst_valid_reg, dst_valid_next;

    // working date and counters
    action_t                  action_reg, action_next;
    logic [AMOUNT_BITS-1:0]   amount_reg, amount_next;
    logic [DAY_BITS-1:0]      d_reg, d_next;
    logic [MONTH_BITS-1:0]    m_reg, m_next;
    logic [YEAR_BITS-1:0]     y_reg, y_next;
    logic [YREM_BITS-1:0]     r400_reg, r400_next;     // year mod 400
    logic [QUOT_BITS-1:0]     quot_reg, quot_next;     // year / 400
    logic                     pass2_reg, pass2_next;   // remainder pass on new year
    logic                     under_reg, under_next;

    // output word
    logic [DAY_BITS-1:0]      od_reg, od_next;
    logic [MONTH_BITS-1:0]    om_reg, om_next;
    logic [YEAR_BITS-1:0]     oy_reg, oy_next;
    logic                     ou_reg, ou_next;

    // shared helpers
    logic                     leap_cur;
    logic                     wrap;
    logic [MONTH_BITS-1:0]    m_prev;
    logic [DAY_BITS-1:0]      len_cur;
    logic [DAY_BITS-1:0]      len_prev;
    logic [YREM_BITS-1:0]     r400_dec;
    logic [PROD_BITS-1:0]     quot_prod;
    logic [YEAR_BITS-1:0]     rem_full;
    logic [AMT_CMP_BITS-1:0]  amt_ext, d_ext;
    logic [YR_CMP_BITS-1:0]   amt_yext, y_ext;

    always_comb
    begin
        leap_cur  = is_leap(r400_reg);
        wrap      = (m_reg == JANUARY);
        m_prev    = wrap ? DECEMBER : (m_reg - MONTH_BITS'(1));
        len_cur   = days_in(m_reg, leap_cur);
        // month before stays in the same year unless wrapping to December (31 days)
        len_prev  = days_in(m_prev, leap_cur);
        r400_dec  = (r400_reg == '0) ? YREM_BITS'(LEAP_CYCLE - 1) : (r400_reg - YREM_BITS'(1));
        // year / 400 is registered in ST_QUOT, year - 400 * quotient in ST_MOD
        quot_prod = PROD_BITS'(y_reg) * PROD_BITS'(RECIP_400);
        rem_full  = y_reg - YEAR_BITS'(quot_reg) * YEAR_BITS'(LEAP_CYCLE);
        amt_ext   = AMT_CMP_BITS'(amount_reg);
        d_ext     = AMT_CMP_BITS'(d_reg);
        amt_yext  = YR_CMP_BITS'(amount_reg);
        y_ext     = YR_CMP_BITS'(y_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        dst_valid_next = dst_valid_reg;
        action_next    = action_reg;
        amount_next    = amount_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        y_next         = y_reg;
        r400_next      = r400_reg;
        quot_next      = quot_reg;
        pass2_next     = pass2_reg;
        under_next     = under_reg;
        od_next        = od_reg;
        om_next        = om_reg;
        oy_next        = oy_reg;
        ou_next        = ou_reg;

        if (dst_valid_reg && !dst_stall)
        begin
            dst_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (src_valid)
                begin
                    action_next  = action_t'(action);
                    amount_next  = amount;
                    d_next       = (day == '0) ? DAY_FIRST : day;
                    if (month == '0)
                        m_next = JANUARY;
                    else if (month > DECEMBER)
                        m_next = DECEMBER;
                    else
                        m_next = month;
                    y_next       = year;
                    r400_next    = '0;
                    pass2_next   = 1'b0;
                    under_next   = 1'b0;
                    state_next   = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                quot_next  = quot_prod[RECIP_SHIFT +: QUOT_BITS];
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                r400_next  = rem_full[YREM_BITS-1:0];
                state_next = pass2_reg ? ST_YFIX : ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (d_reg > len_cur)
                    d_next = len_cur;
                case (action_reg)
                    ACT_DAYS:   state_next = ST_DAYS;
                    ACT_MONTHS: state_next = ST_MONTHS;
                    ACT_YEARS:  state_next = ST_YSUB;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_DAYS:
            begin
                if (amount_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (amt_ext < d_ext)
                begin
                    d_next     = DAY_BITS'(d_ext - amt_ext);
                    state_next = ST_DONE;
                end
                else if (wrap && (y_reg == '0))
                begin
                    under_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    amount_next = AMOUNT_BITS'(amt_ext - d_ext);
                    m_next      = m_prev;
                    d_next      = len_prev;
                    if (wrap)
                    begin
                        y_next    = y_reg - YEAR_BITS'(1);
                        r400_next = r400_dec;
                    end
                end
            end
            ST_MONTHS:
            begin
                if (amount_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (wrap && (y_reg == '0))
                begin
                    under_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    amount_next = amount_reg - AMOUNT_BITS'(1);
                    m_next      = m_prev;
                    if (d_reg > len_prev)
                        d_next = len_prev;
                    if (wrap)
                    begin
                        y_next    = y_reg - YEAR_BITS'(1);
                        r400_next = r400_dec;
                    end
                end
            end
            ST_YSUB:
            begin
                if (amt_yext > y_ext)
                begin
                    under_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    y_next       = YEAR_BITS'(y_ext - amt_yext);
                    pass2_next   = 1'b1;
                    state_next   = ST_QUOT;
                end
            end
            ST_YFIX:
            begin
                if ((m_reg == FEBRUARY) && (d_reg == DAY_29) && !leap_cur)
                    d_next = DAY_28;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!dst_valid_reg || !dst_stall)
                begin
                    od_next        = under_reg ? DAY_FIRST : d_reg;
                    om_next        = under_reg ? JANUARY : m_reg;
                    oy_next        = under_reg ? '0 : y_reg;
                    ou_next        = under_reg;
                    dst_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        amount_reg  <= amount_next;
        d_reg       <= d_next;
        m_reg       <= m_next;
        y_reg       <= y_next;
        r400_reg    <= r400_next;
        quot_reg    <= quot_next;
        pass2_reg   <= pass2_next;
        under_reg   <= under_next;
        od_reg      <= od_next;
        om_reg      <= om_next;
        oy_reg      <= oy_next;
        ou_reg      <= ou_next;
    end

    assign src_stall = (state_reg != ST_IDLE);
    assign dst_valid = dst_valid_reg;
    assign new_day   = od_reg;
    assign new_month = om_reg;
    assign new_year  = oy_reg;
    assign underflow = ou_reg;

`ifndef ASSERT_OFF
    // quotient cycle is always followed by the remainder cycle
    a_mod_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QUOT) |=> (state_reg == ST_MOD))
        else $error("remainder cycle did not follow quotient");

    // year remainder stays below 400 while the walk uses it
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DAYS) || (state_reg == ST_MONTHS) || (state_reg == ST_YFIX) |->
            (r400_reg < YREM_BITS'(LEAP_CYCLE)))
        else $error("year remainder out of range");

    // working date stays a legal date during the walk
    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DAYS) || (state_reg == ST_MONTHS) |->
            (m_reg >= JANUARY) && (m_reg <= DECEMBER) && (d_reg != '0))
        else $error("working date out of range");

    // saturated result is exactly 1/1/0
    a_under_sat: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid_reg && ou_reg |->
            (od_reg == DAY_FIRST) && (om_reg == JANUARY) && (oy_reg == '0))
        else $error("underflow word not saturated");

    // a new result word is only produced from the done state
    a_word_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result word raised outside done state");
`endif

endmodule

### dv/gregorian_date_subtract_tb.sv
// ---------------------------------------------------------------------------
// gregorian_date_subtract_tb: regression for the date subtract block
// Drives dated words through the valid/stall source port, predicts every
// result word with a calendar model kept here, and checks each result word
// field by field in order. Directed corner dates come first, then random
// words with and without idle cycles, then a long hold-off on the result side.
// ---------------------------------------------------------------------------
module gregorian_date_subtract_tb;
    import gds_pkg::*;

    // One expected result word
    typedef struct {
        logic [DAY_BITS-1:0]   day;
        logic [MONTH_BITS-1:0] month;
        logic [YEAR_BITS-1:0]  year;
        logic                  underflow;
    } date_result_t;

    localparam int HOLD_CYCLES  = 400;  // result side hold-off for the pressure test
    localparam int IDLE_PERCENT = 12;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   src_valid = 1'b0;
    logic                   src_stall;
    logic [ACTION_BITS-1:0] action    = '0;
    logic [AMOUNT_BITS-1:0] amount    = '0;
    logic [DAY_BITS-1:0]    day       = DAY_FIRST;
    logic [MONTH_BITS-1:0]  month     = JANUARY;
    logic [YEAR_BITS-1:0]   year      = '0;
    logic                   dst_valid;
    logic                   dst_stall = 1'b0;
    logic [DAY_BITS-1:0]    new_day;
    logic [MONTH_BITS-1:0]  new_month;
    logic [YEAR_BITS-1:0]   new_year;
    logic                   underflow;

    date_result_t pending_dates[$];  // predicted results, oldest first
    int           mismatches = 0;
    bit           idle_on    = 1'b1; // random idling on both sides
    bit           hold_go    = 1'b0; // asks the result side for a long hold-off

    gregorian_date_subtract DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .action    (action),
        .amount    (amount),
        .day       (day),
        .month     (month),
        .year      (year),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .new_day   (new_day),
        .new_month (new_month),
        .new_year  (new_year),
        .underflow (underflow)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Calendar model
    // -----------------------------------------------------------------------

    // Gregorian rule; year 0 counts as leap (divisible by 400)
    function automatic bit leap_gregorian(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        int unsigned len;
        if (m == FEBRUARY)
            len = leap_gregorian(y) ? 29 : 28;
        else if (m == APRIL || m == JUNE || m == SEPTEMBER || m == NOVEMBER)
            len = 30;
        else
            len = 31;
        return len;
    endfunction

    // Back one month; sets under instead of going before January of year 0
    function automatic void step_back_month(inout int unsigned m, inout int unsigned y,
                                            inout bit under);
        if (m == JANUARY)
        begin
            if (y == 0)
                under = 1'b1;
            else
            begin
                y = y - 1;
                m = DECEMBER;
            end
        end
        else
            m = m - 1;
    endfunction

    // Predicts the earlier date for one source word
    function automatic date_result_t subtract_date(input action_t act,
                                                   input logic [AMOUNT_BITS-1:0] amt,
                                                   input logic [DAY_BITS-1:0] d_in,
                                                   input logic [MONTH_BITS-1:0] m_in,
                                                   input logic [YEAR_BITS-1:0] y_in);
        int unsigned  left;
        int unsigned  d;
        int unsigned  m;
        int unsigned  y;
        int unsigned  i;
        bit           under;
        date_result_t r;
        left  = amt;
        d     = d_in;
        m     = m_in;
        y     = y_in;
        under = 1'b0;
        // out-of-range month and day are pulled into range first
        if (m < JANUARY)
            m = JANUARY;
        if (m > DECEMBER)
            m = DECEMBER;
        if (d < 1)
            d = 1;
        if (d > month_length(m, y))
            d = month_length(m, y);
        case (act)
            ACT_DAYS:
            begin
                // use up the current month, then land on the last day of the one before
                while (left > 0 && !under)
                begin
                    if (left < d)
                    begin
                        d    = d - left;
                        left = 0;
                    end
                    else
                    begin
                        left = left - d;
                        step_back_month(m, y, under);
                        if (!under)
                            d = month_length(m, y);
                    end
                end
            end
            ACT_MONTHS:
            begin
                for (i = 0; i < left && !under; i++)
                begin
                    step_back_month(m, y, under);
                    if (!under && d > month_length(m, y))
                        d = month_length(m, y);
                end
            end
            ACT_YEARS:
            begin
                if (left > y)
                    under = 1'b1;
                else
                begin
                    y = y - left;
                    if (m == FEBRUARY && d == 29 && !leap_gregorian(y))
                        d = 28;
                end
            end
            default: ;  // pass-through: clamped date, no flag
        endcase
        if (under)
        begin
            d = 1;
            m = JANUARY;
            y = 0;
        end
        r.day       = d[DAY_BITS-1:0];
        r.month     = m[MONTH_BITS-1:0];
        r.year      = y[YEAR_BITS-1:0];
        r.underflow = under;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Source side
    // -----------------------------------------------------------------------

    // Offers one word and returns at the edge it is taken. Valid stays high on
    // return so the next word can follow without a bubble.
    task automatic offer_date(input action_t act, input logic [AMOUNT_BITS-1:0] amt,
                              input logic [DAY_BITS-1:0] d, input logic [MONTH_BITS-1:0] m,
                              input logic [YEAR_BITS-1:0] y);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        action    <= act;
        amount    <= amt;
        day       <= d;
        month     <= m;
        year      <= y;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        pending_dates.push_back(subtract_date(act, amt, d, m, y));
    endtask

    // Random word. Tidy words are real dates with a real action; the rest
    // exercise every field bit, including day 0, months 0/13-15 and action 3.
    task automatic offer_random_date(input bit tidy);
        action_t                act;
        logic [AMOUNT_BITS-1:0] amt;
        logic [DAY_BITS-1:0]    d;
        logic [MONTH_BITS-1:0]  m;
        logic [YEAR_BITS-1:0]   y;
        int unsigned            pick;
        pick = $urandom_range(99);
        // mostly short walks, a few long ones
        if (pick < 60)
            amt = AMOUNT_BITS'($urandom_range(60));
        else if (pick < 85)
            amt = AMOUNT_BITS'($urandom_range(400));
        else
            amt = AMOUNT_BITS'($urandom_range(4095));
        case ($urandom_range(3))
            0:       y = YEAR_BITS'($urandom_range(20));
            1:       y = YEAR_BITS'(1500 + $urandom_range(1000));
            2:       y = YEAR_BITS'(100 * $urandom_range(40));  // centuries, leap and not
            default: y = YEAR_BITS'($urandom_range(65535));
        endcase
        if (tidy)
        begin
            act = action_t'($urandom_range(ACT_YEARS));
            m   = MONTH_BITS'($urandom_range(DECEMBER, JANUARY));
            if ($urandom_range(4) == 0)
                d = DAY_BITS'(month_length(m, y));
            else
                d = DAY_BITS'($urandom_range(month_length(m, y), 1));
        end
        else
        begin
            act = action_t'($urandom_range(ACT_NONE));
            m   = MONTH_BITS'($urandom_range(15));
            d   = DAY_BITS'($urandom_range(31));
        end
        offer_date(act, amt, d, m, y);
    endtask

    // Lowers valid and waits for every predicted word to come back
    task automatic drain_results(input int settle);
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Result side: random stall, plus a long hold-off on request
    // -----------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                dst_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_go = 1'b0;
                dst_stall <= 1'b0;
            end
            else
                dst_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    // Every accepted result word is compared with the oldest prediction
    always @(posedge clk)
    begin
        date_result_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t: unexpected result word %0d/%0d/%0d underflow %0b",
                         $realtime, new_day, new_month, new_year, underflow);
                mismatches++;
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("new_day", want.day, new_day);
                check_field("new_month", want.month, new_month);
                check_field("new_year", want.year, new_year);
                check_field("underflow", want.underflow, underflow);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    task automatic test_directed_dates;
        // days: zero amount, within the month, exact day count, leap Feb, year wrap
        offer_date(ACT_DAYS, 0, 15, 6, 2020);
        offer_date(ACT_DAYS, 5, 15, 6, 2020);
        offer_date(ACT_DAYS, 1, 1, 3, 2021);
        offer_date(ACT_DAYS, 1, 1, 3, 2024);
        offer_date(ACT_DAYS, 1, 1, 1, 2000);
        offer_date(ACT_DAYS, 1, 1, 1, 0);          // falls off year 0
        offer_date(ACT_DAYS, 4095, 31, 12, 65535);
        offer_date(ACT_DAYS, 4095, 31, 12, 0);
        // months: day clamp into short Feb, leap Feb, longest walk, underflow
        offer_date(ACT_MONTHS, 1, 31, 3, 2023);
        offer_date(ACT_MONTHS, 1, 31, 3, 2024);
        offer_date(ACT_MONTHS, 4095, 31, 12, 65535);
        offer_date(ACT_MONTHS, 3, 15, 3, 0);
        offer_date(ACT_MONTHS, 2, 1, 1, 0);
        // years: 29 Feb into non-leap, 400-year step, century step, amount vs year
        offer_date(ACT_YEARS, 1, 29, 2, 2024);
        offer_date(ACT_YEARS, 400, 29, 2, 2000);
        offer_date(ACT_YEARS, 100, 29, 2, 2000);
        offer_date(ACT_YEARS, 6, 10, 7, 5);
        offer_date(ACT_YEARS, 2024, 29, 2, 2024);  // lands on year 0, leap
        offer_date(ACT_YEARS, 4095, 31, 12, 4095);
        offer_date(ACT_YEARS, 0, 31, 5, 65535);
        // out-of-range fields and the pass-through action
        offer_date(ACT_NONE, 4095, 0, 0, 0);
        offer_date(ACT_NONE, 7, 31, 2, 1900);
        offer_date(ACT_NONE, 1, 31, 15, 65535);
        offer_date(ACT_DAYS, 40, 31, 13, 1999);
        offer_date(ACT_MONTHS, 1, 0, 14, 1);
        drain_results(0);
    endtask

    task automatic test_random_idle;
        idle_on = 1'b1;
        repeat (70)
            offer_random_date($urandom_range(99) < 85);
        drain_results(0);
    endtask

    // long stretch with no idling on either side
    task automatic test_random_steady;
        idle_on = 1'b0;
        repeat (40)
            offer_random_date($urandom_range(99) < 85);
        drain_results(0);
        idle_on = 1'b1;
    endtask

    // result side holds off while short words keep coming, so the output
    // register fills and the source side has to stall
    task automatic test_output_backpressure;
        hold_go = 1'b1;
        repeat (8)
            offer_date(action_t'($urandom_range(ACT_NONE)),
                       AMOUNT_BITS'($urandom_range(40)),
                       DAY_BITS'($urandom_range(28, 1)),
                       MONTH_BITS'($urandom_range(DECEMBER, JANUARY)),
                       YEAR_BITS'($urandom_range(3000)));
        drain_results(0);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_dates();
        test_random_idle();
        test_random_steady();
        test_output_backpressure();
        drain_results(64);
        if (mismatches == 0 && pending_dates.size() == 0)
            $display("gregorian_date_subtract regression: pass");
        else
            $display("gregorian_date_subtract regression: fail");
        $finish;
    end

    // Several times the slowest legal run
    initial
    begin
        #80000000;
        $display("gregorian_date_subtract regression: fail");
        $finish;
    end

endmodule
